/* design/imt_pkg.sv */
// Shared constants, status codes and controller/datapath interface types
// for the iterative mean threshold block. No dependencies.
package imt_pkg;

  localparam int COUNT_BITS_DEF = 24;
  localparam int NUM_BINS       = 256;
  localparam int BIN_BITS       = 8;
  localparam int QUOT_BITS      = 8;
  localparam int ADDR_BITS      = 3;

  localparam logic [7:0] START_RESET = 8'd100;
  localparam logic [7:0] LIMIT_RESET = 8'd64;
  localparam logic [7:0] MIN_CHANGE  = 8'd2;

  // Register select bit within paddr (registers sit at byte offsets 0 and 4).
  localparam int         REG_SEL_BIT = 2;
  localparam logic       REG_START   = 1'b0;
  localparam logic       REG_LIMIT   = 1'b1;

  localparam logic [1:0] ST_CONVERGED = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_LIMIT     = 2'd2;

  typedef struct packed {
    logic       init;
    logic       scan_start;
    logic       div_start;
    logic       div_sel_lo;
    logic       cap_hi;
    logic       update;
    logic       load_result;
    logic [1:0] result_status;
    logic       clear_hist;
  } ctrl_cmd_t;

  typedef struct packed {
    logic converged;
    logic at_limit;
    logic class_empty;
    logic scan_idle;
    logic div_idle;
    logic out_full;
  } dp_status_t;

endpackage

/* design/imt_div.sv */
// Restoring divider producing an 8-bit quotient, one bit per cycle.
// Depends on imt_pkg. The caller guarantees a nonzero divisor and a
// dividend below 256 times the divisor.
module imt_div #(
  parameter int NBits = imt_pkg::COUNT_BITS_DEF + imt_pkg::BIN_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [NBits+imt_pkg::QUOT_BITS-1:0]  dividend_i,
  input  logic [NBits-1:0]                     divisor_i,
  output logic                                 busy_o,
  output logic [imt_pkg::QUOT_BITS-1:0]        quotient_o
);
  import imt_pkg::*;

  localparam int SBits    = NBits + QUOT_BITS;
  localparam int StepBits = $clog2(QUOT_BITS);

  logic                 busy_q;
  logic [StepBits-1:0]  step_q;
  logic [SBits-1:0]     rem_q;
  logic [SBits-1:0]     dsh_q;
  logic [QUOT_BITS-1:0] quot_q;
  logic                 fits;

  assign fits = rem_q >= dsh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 1'b1;
      if (step_q == StepBits'(QUOT_BITS - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= dividend_i;
      dsh_q  <= SBits'(divisor_i) << (QUOT_BITS - 1);
      quot_q <= '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= rem_q - dsh_q;
      end
      quot_q <= {quot_q[QUOT_BITS-2:0], fits};
      dsh_q  <= dsh_q >> 1;
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quot_q;

endmodule

/* design/imt_datapath.sv */
// Datapath: histogram memory with bin valid bits, pixel update pipeline,
// class scan accumulators, shared divider, threshold and result registers.
// Depends on imt_pkg and imt_div.
module imt_datapath #(
  parameter int CountBits = imt_pkg::COUNT_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_accept_i,
  input  logic [7:0]         pixel_value_i,
  input  logic [7:0]         start_threshold_i,
  input  logic [7:0]         iteration_limit_i,
  input  imt_pkg::ctrl_cmd_t cmd_i,
  output imt_pkg::dp_status_t sts_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [7:0]         threshold_o,
  output logic [1:0]         status_o,
  output logic [7:0]         rounds_used_o
);
  import imt_pkg::*;

  localparam int NBits = CountBits + BIN_BITS;
  localparam int PBits = CountBits + BIN_BITS;
  localparam int SBits = NBits + QUOT_BITS;

  // Histogram storage.
  logic [CountBits-1:0] mem [NUM_BINS];
  logic [NUM_BINS-1:0]  bin_vld_q;
  logic [CountBits-1:0] rdata_q;
  logic                 rvld_q;
  logic [BIN_BITS-1:0]  rd_addr;

  // Pixel update pipeline.
  logic                 s2_vld_q;
  logic [BIN_BITS-1:0]  s2_addr_q;
  logic                 fwd_vld_q;
  logic [BIN_BITS-1:0]  fwd_addr_q;
  logic [CountBits-1:0] fwd_data_q;
  logic [CountBits-1:0] base_cnt;
  logic [CountBits-1:0] wr_data;
  logic                 wr_en;

  // Scan pipeline and accumulators.
  logic                 scan_run_q;
  logic [BIN_BITS-1:0]  scan_addr_q;
  logic                 sv1_q;
  logic [BIN_BITS-1:0]  sb1_q;
  logic [CountBits-1:0] cnt1;
  logic                 sv2_q;
  logic [PBits-1:0]     prod_q;
  logic [CountBits-1:0] cnt2_q;
  logic                 hi2_q;
  logic [NBits-1:0]     hi_n_q, lo_n_q;
  logic [SBits-1:0]     hi_s_q, lo_s_q;
  logic                 scan_idle;

  // Iteration registers.
  logic [7:0]           cur_q, prev_q, rounds_q, qh_q;
  logic [7:0]           diff;
  logic [8:0]           mean_sum;
  logic                 div_busy;
  logic [QUOT_BITS-1:0] quot;

  // Result register.
  logic                 out_valid_q;
  logic [7:0]           thr_out_q, rounds_out_q;
  logic [1:0]           status_out_q;

  assign rd_addr = scan_run_q ? scan_addr_q : pixel_value_i;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[s2_addr_q] <= wr_data;
    end
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_vld_q <= '0;
      rvld_q    <= 1'b0;
    end else begin
      rvld_q <= bin_vld_q[rd_addr];
      if (cmd_i.clear_hist) begin
        bin_vld_q <= '0;
      end else if (wr_en) begin
        bin_vld_q[s2_addr_q] <= 1'b1;
      end
    end
  end

  // A bin written on the previous edge has not yet reached the read data,
  // so its new count is forwarded.
  assign base_cnt = (fwd_vld_q && (fwd_addr_q == s2_addr_q)) ? fwd_data_q :
                    (rvld_q ? rdata_q : '0);
  assign wr_data  = (&base_cnt) ? base_cnt : base_cnt + 1'b1;
  assign wr_en    = s2_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q  <= 1'b0;
      fwd_vld_q <= 1'b0;
    end else begin
      s2_vld_q  <= in_accept_i;
      fwd_vld_q <= wr_en;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_addr_q  <= pixel_value_i;
    fwd_addr_q <= s2_addr_q;
    fwd_data_q <= wr_data;
  end

  // Scan: read every bin, multiply by its value, accumulate per class.
  assign cnt1 = rvld_q ? rdata_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_run_q  <= 1'b0;
      scan_addr_q <= '0;
      sv1_q       <= 1'b0;
      sv2_q       <= 1'b0;
    end else begin
      sv1_q <= scan_run_q;
      sv2_q <= sv1_q;
      if (cmd_i.scan_start) begin
        scan_run_q  <= 1'b1;
        scan_addr_q <= '0;
      end else if (scan_run_q) begin
        scan_addr_q <= scan_addr_q + 1'b1;
        if (&scan_addr_q) begin
          scan_run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sb1_q  <= scan_addr_q;
    prod_q <= PBits'(cnt1) * PBits'(sb1_q);
    cnt2_q <= cnt1;
    hi2_q  <= sb1_q > cur_q;
    if (cmd_i.scan_start) begin
      hi_n_q <= '0;
      lo_n_q <= '0;
      hi_s_q <= '0;
      lo_s_q <= '0;
    end else if (sv2_q) begin
      if (hi2_q) begin
        hi_n_q <= hi_n_q + NBits'(cnt2_q);
        hi_s_q <= hi_s_q + SBits'(prod_q);
      end else begin
        lo_n_q <= lo_n_q + NBits'(cnt2_q);
        lo_s_q <= lo_s_q + SBits'(prod_q);
      end
    end
  end

  assign scan_idle = !scan_run_q && !sv1_q && !sv2_q;

  imt_div #(
    .NBits(NBits)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (cmd_i.div_sel_lo ? lo_s_q : hi_s_q),
    .divisor_i  (cmd_i.div_sel_lo ? lo_n_q : hi_n_q),
    .busy_o     (div_busy),
    .quotient_o (quot)
  );

  assign mean_sum = {1'b0, qh_q} + {1'b0, quot};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q    <= '0;
      prev_q   <= '0;
      rounds_q <= '0;
    end else if (cmd_i.init) begin
      cur_q    <= start_threshold_i;
      prev_q   <= '0;
      rounds_q <= '0;
    end else if (cmd_i.update) begin
      prev_q   <= cur_q;
      cur_q    <= mean_sum[8:1];
      rounds_q <= rounds_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_hi) begin
      qh_q <= quot;
    end
  end

  assign diff = (cur_q > prev_q) ? cur_q - prev_q : prev_q - cur_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_result) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      thr_out_q    <= cur_q;
      status_out_q <= cmd_i.result_status;
      rounds_out_q <= rounds_q;
    end
  end

  assign sts_o.converged   = diff < MIN_CHANGE;
  assign sts_o.at_limit    = rounds_q >= iteration_limit_i;
  assign sts_o.class_empty = (hi_n_q == '0) || (lo_n_q == '0);
  assign sts_o.scan_idle   = scan_idle;
  assign sts_o.div_idle    = !div_busy;
  assign sts_o.out_full    = out_valid_q && !out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign threshold_o   = thr_out_q;
  assign status_o      = status_out_q;
  assign rounds_used_o = rounds_out_q;

`ifndef NO_ASSERTIONS
  // The histogram is only cleared once every pixel write and scan has finished.
  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear_hist |-> !s2_vld_q && scan_idle)
    else $error("histogram cleared while busy");
  // A started scan must be in flight on the next cycle.
  a_scan_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_start |=> !scan_idle)
    else $error("scan did not start");
  // Pixel writes and the scan share the read port and never overlap.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> !scan_run_q)
    else $error("pixel write during scan");
`endif

endmodule

/* design/imt_ctrl.sv */
// Controller state machine: sequences histogram fill, threshold rounds,
// divisions and the result hand-off. Depends on imt_pkg.
module imt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_accept_i,
  input  logic                last_pixel_i,
  output logic                in_ready_o,
  input  imt_pkg::dp_status_t sts_i,
  output imt_pkg::ctrl_cmd_t  cmd_o
);
  import imt_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FLUSH = 7'b0000010,
    S_CHECK = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_DIVH  = 7'b0010000,
    S_DIVL  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] status_q, status_d;

  always_comb begin
    state_d    = state_q;
    status_d   = status_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_accept_i && last_pixel_i) begin
          state_d = S_FLUSH;
        end
      end
      // The last pixel's bin update lands during this cycle.
      S_FLUSH: begin
        cmd_o.init = 1'b1;
        state_d    = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.converged) begin
          status_d = ST_CONVERGED;
          state_d  = S_DONE;
        end else if (sts_i.at_limit) begin
          status_d = ST_LIMIT;
          state_d  = S_DONE;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.scan_idle) begin
          if (sts_i.class_empty) begin
            status_d = ST_EMPTY;
            state_d  = S_DONE;
          end else begin
            cmd_o.div_start = 1'b1;
            state_d         = S_DIVH;
          end
        end
      end
      S_DIVH: begin
        if (sts_i.div_idle) begin
          cmd_o.cap_hi     = 1'b1;
          cmd_o.div_start  = 1'b1;
          cmd_o.div_sel_lo = 1'b1;
          state_d          = S_DIVL;
        end
      end
      S_DIVL: begin
        if (sts_i.div_idle) begin
          cmd_o.update = 1'b1;
          state_d      = S_CHECK;
        end
      end
      S_DONE: begin
        if (!sts_i.out_full) begin
          cmd_o.load_result   = 1'b1;
          cmd_o.result_status = status_q;
          cmd_o.clear_hist    = 1'b1;
          state_d             = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= ST_CONVERGED;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

`ifndef NO_ASSERTIONS
  // A result is never loaded over one that is still waiting.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_result |-> !sts_i.out_full)
    else $error("result overwritten");
  // A round is only started when another round is both needed and allowed.
  a_scan_needed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.scan_start |-> !sts_i.converged && !sts_i.at_limit)
    else $error("unneeded round started");
  // Divisions only start on an idle divider with both classes populated.
  a_div_safe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> sts_i.div_idle && !sts_i.class_empty)
    else $error("unsafe division start");
`endif

endmodule

/* design/iterative_mean_threshold_core.sv */
// Top level of the iterative mean threshold block: configuration registers,
// controller and datapath. Depends on imt_pkg, imt_ctrl and imt_datapath.
//
//   Channel   Handshake              Payload
//   input     in_valid_i/in_ready_o  pixel_value_i, last_pixel_i
//   output    out_valid_o/out_ready_i threshold_o, status_o, rounds_used_o
//   config    psel/penable/pready    paddr, pwrite, pwdata, prdata
//
// Pixels are taken one per cycle while the image is being counted. After the
// last item, the result is worked out in rounds: each round is one read sweep
// of the histogram memory plus pipeline fill, then two divisions on the shared
// divider. No item is taken in that time.
// Reset clears the bin valid bits at once, so no clearing pass is needed.
// A waiting result holds the output while the next image is counted.
module iterative_mean_threshold_core #(
  parameter int CountBits = imt_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [7:0]                     pixel_value_i,
  input  logic                           last_pixel_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [7:0]                     threshold_o,
  output logic [1:0]                     status_o,
  output logic [7:0]                     rounds_used_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [imt_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import imt_pkg::*;

  logic       in_accept;
  logic       cfg_wr;
  logic [7:0] start_q;
  logic [7:0] limit_q;
  ctrl_cmd_t  cmd;
  dp_status_t sts;

  assign in_accept = in_valid_i && in_ready_o;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= START_RESET;
      limit_q <= LIMIT_RESET;
    end else if (cfg_wr) begin
      if (paddr[REG_SEL_BIT] == REG_START) begin
        start_q <= pwdata[7:0];
      end else begin
        limit_q <= pwdata[7:0];
      end
    end
  end

  assign prdata = (paddr[REG_SEL_BIT] == REG_LIMIT) ? {24'd0, limit_q} : {24'd0, start_q};

  imt_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_accept_i  (in_accept),
    .last_pixel_i (last_pixel_i),
    .in_ready_o   (in_ready_o),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  imt_datapath #(
    .CountBits(CountBits)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_accept_i       (in_accept),
    .pixel_value_i     (pixel_value_i),
    .start_threshold_i (start_q),
    .iteration_limit_i (limit_q),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .threshold_o       (threshold_o),
    .status_o          (status_o),
    .rounds_used_o     (rounds_used_o)
  );

endmodule

/* tb/iterative_mean_threshold_core_test.sv */
// Self-checking testbench for iterative_mean_threshold_core: streams images through
// the pixel channel, predicts each threshold result and checks it field by field.
// Depends on imt_pkg and the iterative_mean_threshold_core RTL only.
`timescale 1ns / 1ps

module iterative_mean_threshold_core_test;
  import imt_pkg::*;

  localparam int CountBits = COUNT_BITS_DEF;
  localparam int MaxGap    = 6;
  localparam int MaxStall  = 12;

  typedef struct packed {
    logic [7:0] threshold;
    logic [1:0] status;
    logic [7:0] rounds_used;
  } threshold_result_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 in_valid_i    = 1'b0;
  logic                 in_ready_o;
  logic [7:0]           pixel_value_i = '0;
  logic                 last_pixel_i  = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i   = 1'b0;
  logic [7:0]           threshold_o;
  logic [1:0]           status_o;
  logic [7:0]           rounds_used_o;
  logic                 psel          = 1'b0;
  logic                 penable       = 1'b0;
  logic                 pwrite        = 1'b0;
  logic [ADDR_BITS-1:0] paddr         = '0;
  logic [31:0]          pwdata        = '0;
  logic [31:0]          prdata;
  logic                 pready;

  // Predicted block state: histogram and the two configuration registers.
  logic [CountBits-1:0] bin_count [NUM_BINS];
  logic [7:0]           cfg_start = START_RESET;
  logic [7:0]           cfg_limit = LIMIT_RESET;
  threshold_result_t    expected_results [$];

  int                   error_count  = 0;
  int                   burst_left   = 0;
  int                   hold_left    = 0;
  int                   stall_left   = 0;
  bit                   gaps_on      = 1'b0;
  bit                   stalls_on    = 1'b0;
  longint unsigned      cycle_budget = 0;
  longint unsigned      cycles_run   = 0;

  iterative_mean_threshold_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pixel_value_i (pixel_value_i),
    .last_pixel_i  (last_pixel_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .threshold_o   (threshold_o),
    .status_o      (status_o),
    .rounds_used_o (rounds_used_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Isodata iteration over the predicted histogram with the current settings.
  function automatic threshold_result_t predict_threshold();
    int unsigned       cur;
    int unsigned       prev;
    int unsigned       diff;
    int unsigned       rounds;
    longint unsigned   hi_n, hi_s, lo_n, lo_s;
    threshold_result_t res;
    cur        = 32'(cfg_start);
    prev       = 0;
    rounds     = 0;
    res.status = ST_CONVERGED;
    while (1'b1) begin
      diff = (cur > prev) ? cur - prev : prev - cur;
      if (diff < MIN_CHANGE) break;
      if (rounds >= cfg_limit) begin
        res.status = ST_LIMIT;
        break;
      end
      hi_n = 0;
      hi_s = 0;
      lo_n = 0;
      lo_s = 0;
      for (int v = 0; v < NUM_BINS; v++) begin
        if (v > cur) begin
          hi_n += 64'(bin_count[v]);
          hi_s += longint'(bin_count[v]) * v;
        end else begin
          lo_n += 64'(bin_count[v]);
          lo_s += longint'(bin_count[v]) * v;
        end
      end
      if (hi_n == 0 || lo_n == 0) begin
        res.status = ST_EMPTY;
        break;
      end
      prev = cur;
      cur  = int'((hi_s / hi_n + lo_s / lo_n) / 2);
      rounds++;
    end
    res.threshold   = cur[7:0];
    res.rounds_used = rounds[7:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
  endtask

  // Offers one pixel and returns at the edge that accepts it, valid still high.
  task automatic send_pixel(input logic [7:0] value, input logic last);
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if (gaps_on) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, MaxGap)) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    pixel_value_i <= value;
    last_pixel_i  <= last;
    do @(posedge clk_i); while (!in_ready_o);
    cycle_budget += MaxGap + MaxStall + 8;
    if (bin_count[value] != '1) bin_count[value]++;
    if (last) begin
      expected_results.insert(expected_results.size(), predict_threshold());
      foreach (bin_count[b]) bin_count[b] = '0;
      cycle_budget += 300 * (longint'(cfg_limit) + 1) + 300;
    end
  endtask

  task automatic send_image(input int pixel_count);
    int         kind;
    int         centre_a;
    int         centre_b;
    int         spread;
    int         level;
    logic [7:0] value;
    kind     = $urandom_range(0, 3);
    centre_a = $urandom_range(0, 255);
    centre_b = $urandom_range(0, 255);
    spread   = $urandom_range(0, 20);
    for (int i = 0; i < pixel_count; i++) begin
      case (kind)
        0: value = 8'($urandom_range(0, 255));
        1: begin
          // Two clusters, the shape the iteration is meant for.
          level = ($urandom_range(0, 1) ? centre_a : centre_b)
                  + int'($urandom_range(0, 2 * spread)) - spread;
          if (level < 0) level = 0;
          if (level > 255) level = 255;
          value = level[7:0];
        end
        2: value = centre_a[7:0];
        default: value = $urandom_range(0, 1) ? 8'hFF :
                         ($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 255)));
      endcase
      send_pixel(value, i == pixel_count - 1);
    end
  endtask

  // Drops valid, waits for every expected result, then lets the block go quiet.
  task automatic settle_block();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (32) @(posedge clk_i);
  endtask

  // Writes one register, then reads it back.
  task automatic write_register(input logic sel, input logic [7:0] value);
    logic [ADDR_BITS-1:0] addr;
    addr              = '0;
    addr[REG_SEL_BIT] = sel;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {24'($urandom), value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (sel == REG_START) cfg_start = value;
    else cfg_limit = value;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[7:0] !== value) report_mismatch("register read-back", prdata[7:0], value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    cycle_budget += 16;
  endtask

  task automatic test_directed_images();
    // Reset settings: a two-level image converges in two rounds.
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b1);
    // A single pixel leaves the upper class empty.
    send_pixel(8'd37, 1'b1);
    settle_block();
    // A limit of one round stops the same two-level image early.
    write_register(REG_LIMIT, 8'd1);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b1);
    settle_block();
    // Starting at zero or one is already within the minimum change.
    write_register(REG_START, 8'd0);
    write_register(REG_LIMIT, 8'd255);
    send_pixel(8'd200, 1'b0);
    send_pixel(8'd10, 1'b0);
    send_pixel(8'd128, 1'b1);
    settle_block();
    write_register(REG_START, 8'd1);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'hFF, 1'b1);
    settle_block();
    // At the top start value every pixel falls in the lower class.
    write_register(REG_START, 8'd255);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h00, 1'b1);
    settle_block();
    write_register(REG_START, 8'd254);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'h80, 1'b1);
    settle_block();
    write_register(REG_START, START_RESET);
    write_register(REG_LIMIT, LIMIT_RESET);
  endtask

  task automatic test_backpressure();
    // The receiver stops for a long stretch; results pile up and the input stalls.
    gaps_on   = 1'b0;
    hold_left = 4000;
    cycle_budget += 4000;
    repeat (4) send_image(8);
    settle_block();
  endtask

  task automatic test_random_images();
    int sent_in_phase;
    int pixel_count;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        1: write_register(REG_LIMIT, 8'd1);
        2: write_register(REG_LIMIT, 8'd255);
        default: write_register(REG_LIMIT, 8'($urandom_range(1, 16)));
      endcase
      write_register(REG_START, 8'($urandom_range(2, 254)));
      stalls_on     = (phase != 0);
      sent_in_phase = 0;
      while (sent_in_phase < 146) begin
        gaps_on     = (phase != 0) && ($urandom_range(0, 3) != 0);
        pixel_count = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64)
                                                  : $urandom_range(1, 16);
        send_image(pixel_count);
        sent_in_phase += pixel_count;
      end
      settle_block();
    end
  endtask

  // Receiver: long hold-off on request, otherwise always ready, or random stall streaks with stalls on.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (!stalls_on) begin
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(0, MaxStall - 1);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    threshold_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, threshold", threshold_o, -1);
      end else begin
        want = expected_results.pop_front();
        if (threshold_o !== want.threshold)
          report_mismatch("threshold", threshold_o, want.threshold);
        if (status_o !== want.status) report_mismatch("status", status_o, want.status);
        if (rounds_used_o !== want.rounds_used)
          report_mismatch("rounds_used", rounds_used_o, want.rounds_used);
      end
    end
  end

  initial begin : watchdog
    do begin
      @(posedge clk_i);
      cycles_run++;
    end while (cycles_run <= 4 * cycle_budget + 100000);
    $display("iterative_mean_threshold_core_test: FAIL");
    $finish;
  end

  initial begin : stimulus
    foreach (bin_count[b]) bin_count[b] = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed_images();
    test_backpressure();
    test_random_images();
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (error_count == 0) begin
      $display("iterative_mean_threshold_core_test: PASS");
    end else begin
      $display("iterative_mean_threshold_core_test: FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
design/imt_pkg.sv
design/imt_div.sv
design/imt_datapath.sv
design/imt_ctrl.sv
design/iterative_mean_threshold_core.sv
tb/iterative_mean_threshold_core_test.sv
